// ----- hdl/bnms_pkg.sv -----
// Shared constants and types for the box non-maximum suppression block.
package bnms_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = IDX_W + 1;

  typedef struct packed {
    logic [9:0]  h;
    logic [9:0]  w;
    logic [11:0] y;
    logic [11:0] x;
  } geo_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             store_we;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic             sel_j;
    logic             rank_clr;
    logic             rank_acc;
    logic             sorted_we;
    logic             gi_ld;
    logic             ai_ld;
    logic             s1_ld;
    logic             s2_ld;
    logic             dec;
    logic             out_ld;
    logic             last_res;
    logic             ovf;
    logic             supp_clr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sup_i;
    logic sup_j;
  } status_t;

endpackage

// ----- hdl/bnms_if.sv -----
// Channel interfaces for box input and result output.
interface bnms_box_if;
  logic               valid;
  logic               ready;
  logic [11:0]        box_x;
  logic [11:0]        box_y;
  logic [9:0]         box_width;
  logic [9:0]         box_height;
  logic signed [31:0] box_score;
  logic               last_box;

  modport source (output valid, box_x, box_y, box_width, box_height, box_score, last_box,
                  input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, box_score, last_box,
                output ready);
endinterface

interface bnms_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] box_index;
  logic       keep;
  logic       end_of_set;
  logic       overflow;

  modport source (output valid, box_index, keep, end_of_set, overflow, input ready);
  modport sink (input valid, box_index, keep, end_of_set, overflow, output ready);
endinterface

// ----- hdl/bnms_dp.sv -----
// Datapath: box stores, ranking compare, overlap arithmetic and result register.
module bnms_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  bnms_pkg::cmd_t                 cmd,
  output bnms_pkg::status_t              status,
  input  logic                           cfg_write_en,
  input  logic [8:0]                     cfg_write_data,
  input  bnms_pkg::geo_t                 in_geo,
  input  logic [31:0]                    in_score,
  output logic [bnms_pkg::IDX_W-1:0]     res_index,
  output logic                           res_keep,
  output logic                           res_end,
  output logic                           res_ovf
);

  logic [8:0] thr;

  bnms_pkg::geo_t                    geo_mem  [bnms_pkg::MAX_BOXES];
  logic [31:0]                       score_mem[bnms_pkg::MAX_BOXES];
  bnms_pkg::geo_t                    sgeo_mem [bnms_pkg::MAX_BOXES];
  logic [bnms_pkg::IDX_W-1:0]        sidx_mem [bnms_pkg::MAX_BOXES];

  bnms_pkg::geo_t                    geo_rd;
  bnms_pkg::geo_t                    sgeo_rd;
  logic [31:0]                       score_rd_i;
  logic [31:0]                       score_rd_j;
  logic [bnms_pkg::IDX_W-1:0]        sidx_rd;
  logic [bnms_pkg::IDX_W-1:0]        rank;
  logic [bnms_pkg::MAX_BOXES-1:0]    supp;

  bnms_pkg::geo_t gi;
  logic [19:0]    ai;
  logic           ov;
  logic [19:0]    inter;
  logic [19:0]    aj;
  logic           big;
  logic           small_i;
  logic           small_j;

  logic [31:0] key_i;
  logic [31:0] key_j;
  logic [12:0] xie, xje, yie, yje;
  logic [12:0] xi_e, xj_e, yi_e, yj_e;
  logic [12:0] iw_w, ih_w;
  logic        ov_c;
  logic [20:0] uni;
  logic [27:0] lhs;
  logic [29:0] rhs;
  logic [20:0] inter2;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 9'd128;
    end else if (cfg_write_en) begin
      thr <= cfg_write_data;
    end
  end

  // Load-order stores.
  always_ff @(posedge clk) begin
    if (cmd.store_we) begin
      geo_mem[cmd.wr_addr]   <= in_geo;
      score_mem[cmd.wr_addr] <= in_score;
    end
    geo_rd     <= geo_mem[cmd.i];
    score_rd_i <= score_mem[cmd.i];
    score_rd_j <= score_mem[cmd.j];
  end

  // Sorted-order stores.
  always_ff @(posedge clk) begin
    if (cmd.sorted_we) begin
      sgeo_mem[rank] <= geo_rd;
      sidx_mem[rank] <= cmd.i;
    end
    sgeo_rd <= sgeo_mem[cmd.sel_j ? cmd.j : cmd.i];
    sidx_rd <= sidx_mem[cmd.i];
  end

  // The bias on the sign bit makes unsigned order match signed score order.
  assign key_i = score_rd_i ^ 32'h8000_0000;
  assign key_j = score_rd_j ^ 32'h8000_0000;

  always_ff @(posedge clk) begin
    if (cmd.rank_clr) begin
      rank <= '0;
    end else if (cmd.rank_acc && ((key_j > key_i) || (key_j == key_i && cmd.j < cmd.i))) begin
      rank <= rank + 1'b1;
    end
  end

  // Overlap stage one: edges, intersection and the other box's area.
  assign xi_e = {1'b0, gi.x};
  assign yi_e = {1'b0, gi.y};
  assign xj_e = {1'b0, sgeo_rd.x};
  assign yj_e = {1'b0, sgeo_rd.y};
  assign xie  = xi_e + {3'b0, gi.w};
  assign yie  = yi_e + {3'b0, gi.h};
  assign xje  = xj_e + {3'b0, sgeo_rd.w};
  assign yje  = yj_e + {3'b0, sgeo_rd.h};
  assign ov_c = !((xie <= xj_e) || (xje <= xi_e) || (yie <= yj_e) || (yje <= yi_e));
  assign iw_w = ((xie < xje) ? xie : xje) - ((xi_e > xj_e) ? xi_e : xj_e);
  assign ih_w = ((yie < yje) ? yie : yje) - ((yi_e > yj_e) ? yi_e : yj_e);

  // Overlap stage two: union, the scaled ratio compare and the containment tests.
  assign uni    = {1'b0, ai} + {1'b0, aj} - {1'b0, inter};
  assign lhs    = {inter, 8'd0};
  assign rhs    = thr * uni;
  assign inter2 = {inter, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.gi_ld) begin
      gi <= sgeo_rd;
    end
    if (cmd.ai_ld) begin
      ai <= gi.w * gi.h;
    end
    if (cmd.s1_ld) begin
      ov    <= ov_c;
      inter <= iw_w[9:0] * ih_w[9:0];
      aj    <= sgeo_rd.w * sgeo_rd.h;
    end
    if (cmd.s2_ld) begin
      big     <= {2'b0, lhs} > rhs;
      small_i <= ({1'b0, ai} < inter2) && (ai < aj);
      small_j <= ({1'b0, aj} < inter2) && (ai >= aj);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.supp_clr) begin
      supp <= '0;
    end else if (cmd.dec && ov) begin
      if (big) begin
        supp[cmd.j] <= 1'b1;
      end else if (small_i) begin
        supp[cmd.i] <= 1'b1;
      end else if (small_j) begin
        supp[cmd.j] <= 1'b1;
      end
    end
  end

  assign status.sup_i = supp[cmd.i];
  assign status.sup_j = supp[cmd.j];

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      res_index <= sidx_rd;
      res_keep  <= !supp[cmd.i];
      res_end   <= cmd.last_res;
      res_ovf   <= cmd.ovf;
    end
  end

endmodule

// ----- hdl/bnms_ctrl.sv -----
// Controller: sequences loading, ranking, pairwise suppression and result output.
module bnms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bnms_pkg::status_t status,
  output bnms_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_RK_INIT = 4'd1;
  localparam logic [3:0] S_RK_RD   = 4'd2;
  localparam logic [3:0] S_RK_CMP  = 4'd3;
  localparam logic [3:0] S_RK_WR   = 4'd4;
  localparam logic [3:0] S_SP_RDI  = 4'd5;
  localparam logic [3:0] S_SP_LDI  = 4'd6;
  localparam logic [3:0] S_SP_AI   = 4'd7;
  localparam logic [3:0] S_SP_RDJ  = 4'd8;
  localparam logic [3:0] S_SP_WJ   = 4'd9;
  localparam logic [3:0] S_SP_C2   = 4'd10;
  localparam logic [3:0] S_SP_DEC  = 4'd11;
  localparam logic [3:0] S_OUT_RD  = 4'd12;
  localparam logic [3:0] S_OUT_LD  = 4'd13;
  localparam logic [3:0] S_OUT_WT  = 4'd14;
  localparam logic [3:0] S_CLR     = 4'd15;

  logic [3:0]                    state, state_next;
  logic [bnms_pkg::IDX_W-1:0]    i, i_next;
  logic [bnms_pkg::IDX_W-1:0]    j, j_next;
  logic [bnms_pkg::CNT_W-1:0]    count, count_next;
  logic                          ovf, ovf_next;
  logic [bnms_pkg::CNT_W-1:0]    count_m1;
  logic                          i_last, j_last, full, take;

  assign count_m1 = count - 1'b1;
  assign i_last   = (i == count_m1[bnms_pkg::IDX_W-1:0]);
  assign j_last   = (j == count_m1[bnms_pkg::IDX_W-1:0]);
  assign full     = (count == bnms_pkg::CNT_W'(bnms_pkg::MAX_BOXES));
  assign in_ready = (state == S_LOAD);
  assign take     = in_valid && in_ready;
  assign out_valid = (state == S_OUT_WT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      i     <= '0;
      j     <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    count_next = count;
    ovf_next   = ovf;
    unique case (state)
      S_LOAD: begin
        if (take) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
          if (in_last) begin
            i_next     = '0;
            state_next = S_RK_INIT;
          end
        end
      end
      S_RK_INIT: begin
        j_next     = '0;
        state_next = S_RK_RD;
      end
      S_RK_RD: state_next = S_RK_CMP;
      S_RK_CMP: begin
        if (j_last) begin
          state_next = S_RK_WR;
        end else begin
          j_next     = j + 1'b1;
          state_next = S_RK_RD;
        end
      end
      S_RK_WR: begin
        if (i_last) begin
          i_next     = '0;
          state_next = S_SP_RDI;
        end else begin
          i_next     = i + 1'b1;
          state_next = S_RK_INIT;
        end
      end
      S_SP_RDI: state_next = S_SP_LDI;
      S_SP_LDI: state_next = S_SP_AI;
      S_SP_AI: begin
        if (i_last) begin
          i_next     = '0;
          state_next = S_OUT_RD;
        end else if (status.sup_i) begin
          i_next     = i + 1'b1;
          state_next = S_SP_RDI;
        end else begin
          j_next     = i + 1'b1;
          state_next = S_SP_RDJ;
        end
      end
      S_SP_RDJ: begin
        if (status.sup_i) begin
          i_next     = i + 1'b1;
          state_next = S_SP_RDI;
        end else if (status.sup_j) begin
          if (j_last) begin
            i_next     = i + 1'b1;
            state_next = S_SP_RDI;
          end else begin
            j_next     = j + 1'b1;
            state_next = S_SP_RDJ;
          end
        end else begin
          state_next = S_SP_WJ;
        end
      end
      S_SP_WJ: state_next = S_SP_C2;
      S_SP_C2: state_next = S_SP_DEC;
      S_SP_DEC: begin
        if (j_last) begin
          i_next     = i + 1'b1;
          state_next = S_SP_RDI;
        end else begin
          j_next     = j + 1'b1;
          state_next = S_SP_RDJ;
        end
      end
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: state_next = S_OUT_WT;
      S_OUT_WT: begin
        if (out_ready) begin
          if (i_last) begin
            state_next = S_CLR;
          end else begin
            i_next     = i + 1'b1;
            state_next = S_OUT_RD;
          end
        end
      end
      S_CLR: begin
        count_next = '0;
        ovf_next   = 1'b0;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.i         = i;
    cmd.j         = j;
    cmd.wr_addr   = count[bnms_pkg::IDX_W-1:0];
    cmd.store_we  = take && !full;
    cmd.sel_j     = (state == S_SP_RDJ) || (state == S_SP_WJ);
    cmd.rank_clr  = (state == S_RK_INIT);
    cmd.rank_acc  = (state == S_RK_CMP);
    cmd.sorted_we = (state == S_RK_WR);
    cmd.gi_ld     = (state == S_SP_LDI);
    cmd.ai_ld     = (state == S_SP_AI);
    cmd.s1_ld     = (state == S_SP_WJ);
    cmd.s2_ld     = (state == S_SP_C2);
    cmd.dec       = (state == S_SP_DEC);
    cmd.out_ld    = (state == S_OUT_LD);
    cmd.last_res  = i_last;
    cmd.ovf       = ovf;
    cmd.supp_clr  = (state == S_CLR);
  end

endmodule

// ----- hdl/box_non_maximum_suppression_top.sv -----
// Top level of the box non-maximum suppression block.
// Boxes arrive one transaction per cycle while the block is loading, up to 64 per set; a box
// beyond that is discarded and every result of the set then carries overflow. The transaction
// with last_box set closes the set: the block stops taking boxes, ranks the n stored boxes by
// descending score (equal scores keep load order) one score pair at a time, then walks every
// kept pair in score order through the shared overlap unit. It then delivers n result
// transactions in score order, each offered until ready is seen, and returns to loading. The
// threshold register may be written while the block is loading with no set open.
module box_non_maximum_suppression_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [8:0]  cfg_write_data,
  bnms_box_if.sink    box_in,
  bnms_result_if.source result
);

  bnms_pkg::cmd_t    cmd;
  bnms_pkg::status_t status;
  bnms_pkg::geo_t    in_geo;

  assign in_geo.x = box_in.box_x;
  assign in_geo.y = box_in.box_y;
  assign in_geo.w = box_in.box_width;
  assign in_geo.h = box_in.box_height;

  // The controller owns the box and loop counters and the handshakes.
  bnms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (box_in.valid),
    .in_last   (box_in.last_box),
    .in_ready  (box_in.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the stores, the overlap arithmetic and the result register.
  bnms_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_geo         (in_geo),
    .in_score       (box_in.box_score),
    .res_index      (result.box_index),
    .res_keep       (result.keep),
    .res_end        (result.end_of_set),
    .res_ovf        (result.overflow)
  );

  // Loading and reporting never overlap.
  assert property (@(posedge clk) disable iff (rst) !(result.valid && box_in.ready))
    else $error("result offered while boxes are being taken");

  // Closing a set stops the intake.
  assert property (@(posedge clk) disable iff (rst)
    box_in.valid && box_in.ready && box_in.last_box |=> !box_in.ready)
    else $error("box intake still open after the last box");

  // Nothing follows the final result of a set.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && result.end_of_set |=> !result.valid)
    else $error("result offered after the end of the set");

endmodule

// ----- test/bnms_checker.sv -----
// Scoreboard for the box suppression block: predicts each set's results and compares them.
`timescale 1ns / 100ps

module bnms_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [8:0] cfg_write_data,
  bnms_box_if        box_mon,
  bnms_result_if     res_mon,
  output int         mismatch_count,
  output int         pending_results,
  output int         results_checked
);

  typedef struct {
    logic [5:0] box_index;
    logic       keep;
    logic       end_of_set;
    logic       overflow;
  } verdict_t;

  bnms_pkg::geo_t     stored_geo [bnms_pkg::MAX_BOXES];
  logic signed [31:0] stored_score [bnms_pkg::MAX_BOXES];
  int                 stored_count;
  bit                 overflow_hit;
  logic [8:0]         iou_limit;
  verdict_t           verdicts_due [$];

  // Rank the stored boxes by score, run greedy suppression and queue one verdict per box.
  function automatic void resolve_set();
    int               rank [bnms_pkg::MAX_BOXES];
    bit               dropped [bnms_pkg::MAX_BOXES];
    int               j;
    int               cur;
    int unsigned      xi, yi, wi, hi, xj, yj, wj, hj, iw, ih;
    longint unsigned  ai, aj, inter, uni;
    verdict_t         v;
    for (int i = 0; i < stored_count; i++) begin
      dropped[i] = 0;
      j = i;
      while (j > 0 && stored_score[rank[j-1]] < stored_score[i]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    for (int i = 0; i < stored_count; i++) begin
      xi = stored_geo[rank[i]].x;
      yi = stored_geo[rank[i]].y;
      wi = stored_geo[rank[i]].w;
      hi = stored_geo[rank[i]].h;
      ai = longint'(wi) * hi;
      if (dropped[rank[i]]) continue;
      for (int k = i + 1; k < stored_count; k++) begin
        if (dropped[rank[i]]) break;
        if (dropped[rank[k]]) continue;
        xj = stored_geo[rank[k]].x;
        yj = stored_geo[rank[k]].y;
        wj = stored_geo[rank[k]].w;
        hj = stored_geo[rank[k]].h;
        if (xi + wi <= xj || xj + wj <= xi || yi + hi <= yj || yj + hj <= yi) continue;
        iw = ((xi + wi < xj + wj) ? xi + wi : xj + wj) - ((xi > xj) ? xi : xj);
        ih = ((yi + hi < yj + hj) ? yi + hi : yj + hj) - ((yi > yj) ? yi : yj);
        inter = longint'(iw) * ih;
        aj = longint'(wj) * hj;
        uni = ai + aj - inter;
        if (inter * 256 > longint'(iou_limit) * uni) dropped[rank[k]] = 1;
        else if (ai < 2 * inter && ai < aj) dropped[rank[i]] = 1;
        else if (aj < 2 * inter && ai >= aj) dropped[rank[k]] = 1;
      end
    end
    for (int i = 0; i < stored_count; i++) begin
      v.box_index  = rank[i][5:0];
      v.keep       = !dropped[rank[i]];
      v.end_of_set = (i == stored_count - 1);
      v.overflow   = overflow_hit;
      verdicts_due.insert(verdicts_due.size(), v);
    end
    stored_count = 0;
    overflow_hit = 0;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      stored_count    = 0;
      overflow_hit    = 0;
      iou_limit       = 9'd128;
      mismatch_count  = 0;
      results_checked = 0;
      verdicts_due.delete();
    end else begin
      if (cfg_write_en) iou_limit = cfg_write_data;
      if (box_mon.valid && box_mon.ready) begin
        if (stored_count < bnms_pkg::MAX_BOXES) begin
          stored_geo[stored_count]   = '{h: box_mon.box_height, w: box_mon.box_width,
                                         y: box_mon.box_y, x: box_mon.box_x};
          stored_score[stored_count] = box_mon.box_score;
          stored_count++;
        end else begin
          overflow_hit = 1;
        end
        if (box_mon.last_box) resolve_set();
      end
      if (res_mon.valid && res_mon.ready) begin
        results_checked++;
        if (verdicts_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result index %0d arrived with nothing expected", $realtime,
                     res_mon.box_index);
        end else begin
          want = verdicts_due.pop_front();
          if (res_mon.box_index !== want.box_index || res_mon.keep !== want.keep ||
              res_mon.end_of_set !== want.end_of_set || res_mon.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected idx %0d keep %0b eos %0b ovf %0b, got %0d %0b %0b %0b",
                       $realtime, want.box_index, want.keep, want.end_of_set, want.overflow,
                       res_mon.box_index, res_mon.keep, res_mon.end_of_set, res_mon.overflow);
          end
        end
      end
    end
    pending_results = verdicts_due.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the box suppression testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;

  // A full set of 64 boxes has a long busy stretch with no transaction, and the watchdog
  // limit leaves a wide margin over it.
  localparam int IDLE_LIMIT  = 150000;
  localparam int SETTLE_WAIT = 40;
  localparam int ITEM_TARGET = 410;

  logic       clk;
  logic       rst;
  logic       cfg_write_en;
  logic [8:0] cfg_write_data;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int boxes_sent;
  int sets_sent;
  int idle_cycles;
  bit no_gaps;   // when set, neither side inserts idle cycles

  bnms_box_if    box_ch ();
  bnms_result_if res_ch ();

  box_non_maximum_suppression_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .box_in         (box_ch.sink),
    .result         (res_ch.source)
  );

  bnms_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .box_mon         (box_ch),
    .res_mon         (res_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The watchdog restarts on every transaction on either channel; the long quiet stretch
  // while the block ranks and suppresses a full set stays well inside the limit.
  always @(posedge clk) begin
    if (rst || (box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: draw a stall per transaction, then hold ready until the transaction happens.
  // Ready is only lowered when a nonzero stall was drawn, so it never drops and rises in one step.
  initial begin
    int stall;
    res_ch.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_ch.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  // Drive one box, entered at a falling edge, and return at the falling edge after acceptance.
  task automatic send_box(input logic [11:0] x, input logic [11:0] y, input logic [9:0] w,
                          input logic [9:0] h, input logic signed [31:0] score,
                          input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      box_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    box_ch.box_x      <= x;
    box_ch.box_y      <= y;
    box_ch.box_width  <= w;
    box_ch.box_height <= h;
    box_ch.box_score  <= score;
    box_ch.last_box   <= last;
    box_ch.valid      <= 1;
    do @(posedge clk); while (!box_ch.ready);
    @(negedge clk);
    boxes_sent++;
    if (last) sets_sent++;
  endtask

  // Wait until the current set has been fully reported and the block is back to loading.
  task automatic drain();
    box_ch.valid <= 0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // The threshold is only changed while the block is idle with no set open.
  task automatic set_threshold(input logic [8:0] value);
    drain();
    cfg_write_en   <= 1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 0;
  endtask

  // A set of boxes scattered around one point, so that many pairs overlap. Scores come from
  // a narrow range most of the time so that ties are common.
  task automatic send_cluster(input int count);
    int cx, cy, spread;
    logic signed [31:0] score;
    cx = $urandom_range(0, 3900);
    cy = $urandom_range(0, 3900);
    spread = $urandom_range(1, 4) * 20;
    for (int n = 0; n < count; n++) begin
      score = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6) - 3;
      if ($urandom_range(0, 7) == 0)
        send_box(12'($urandom), 12'($urandom), 10'($urandom_range(1, 1023)),
                 10'($urandom_range(1, 1023)), score, n == count - 1);
      else
        send_box(12'(cx + $urandom_range(0, spread)), 12'(cy + $urandom_range(0, spread)),
                 10'($urandom_range(1, 150)), 10'($urandom_range(1, 150)), score,
                 n == count - 1);
    end
  endtask

  initial begin
    int size;
    rst            = 1;
    cfg_write_en   = 0;
    cfg_write_data = 0;
    no_gaps        = 0;
    boxes_sent     = 0;
    sets_sent      = 0;
    box_ch.valid      = 0;
    box_ch.box_x      = 0;
    box_ch.box_y      = 0;
    box_ch.box_width  = 1;
    box_ch.box_height = 1;
    box_ch.box_score  = 0;
    box_ch.last_box   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed sets at the default threshold: a lone smallest box with the lowest score,
    // then twin boxes at the far corner with equal scores, where the later one loses.
    send_box(12'd0, 12'd0, 10'd1, 10'd1, 32'sh8000_0000, 1);
    send_box(12'd4095, 12'd4095, 10'd1023, 10'd1023, 32'sh7fff_ffff, 0);
    send_box(12'd4095, 12'd4095, 10'd1023, 10'd1023, 32'sh7fff_ffff, 1);
    // A small box inside a large one: the small box scores higher, so containment drops it.
    send_box(12'd100, 12'd100, 10'd20, 10'd20, 32'sd50, 0);
    send_box(12'd90, 12'd90, 10'd200, 10'd200, 32'sd10, 0);
    // Boxes that only touch edges, and one far away: none of these interact.
    send_box(12'd290, 12'd90, 10'd50, 10'd50, -32'sd1, 0);
    send_box(12'd2000, 12'd3000, 10'd512, 10'd256, 32'sd0, 1);

    // Strictest threshold: any overlap at all drops the lower box.
    set_threshold(9'd0);
    send_box(12'd10, 12'd10, 10'd100, 10'd100, 32'sd5, 0);
    send_box(12'd109, 12'd109, 10'd100, 10'd100, 32'sd7, 0);
    send_box(12'd2730, 12'd1365, 10'd682, 10'd341, 32'sd5, 1);

    // Top legal threshold and beyond: the ratio test can never fire, only containment.
    set_threshold(9'd256);
    send_box(12'd500, 12'd500, 10'd64, 10'd64, 32'sd3, 0);
    send_box(12'd500, 12'd500, 10'd64, 10'd64, 32'sd3, 1);
    set_threshold(9'd511);
    send_box(12'd500, 12'd500, 10'd64, 10'd64, 32'sd3, 0);
    send_box(12'd501, 12'd501, 10'd40, 10'd40, 32'sd9, 1);

    // Capacity: exactly full, then overflowing with the closing box itself discarded.
    set_threshold(9'd128);
    no_gaps = 1;
    send_cluster(bnms_pkg::MAX_BOXES);
    no_gaps = 0;
    send_cluster(bnms_pkg::MAX_BOXES + 2);

    // Random sets, mostly small, with the threshold changed now and then.
    while (boxes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0)
        set_threshold(($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(60, 200)));
      no_gaps = ($urandom_range(0, 4) == 0);
      size = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_cluster(size);
    end

    drain();
    $display("Sent %0d boxes in %0d sets; %0d results checked, %0d mismatches.",
             boxes_sent, sets_sent, results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bnms_pkg.sv
hdl/bnms_if.sv
hdl/bnms_dp.sv
hdl/bnms_ctrl.sv
hdl/box_non_maximum_suppression_top.sv
test/bnms_checker.sv
test/testbench.sv
